// ===== rtl/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the triangular solve block.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int SIZE_DEF   = 8;
  localparam int FRAC_DEF   = 16;
  localparam int DATA_W     = 32;
  localparam int ACC_W      = 70;
  localparam int CMD_W      = 2;
  localparam int POS_W      = 3;
  localparam int STAT_W     = 2;
  localparam int CFG_SZ_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int IN_DATA_W  = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A  = 2'd0,
    CMD_WR_B  = 2'd1,
    CMD_SOLVE = 2'd2,
    CMD_RD_B  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_INVALID  = 2'd2
  } stat_t;

  localparam logic [CFG_IDX_W-1:0] REG_TRI_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_UNIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_UNIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE      = 2'd3;

  typedef struct packed {
    logic                triangle_upper;
    logic                a_unit_diag;
    logic                b_unit_diag;
    logic [CFG_SZ_W-1:0] size_in_use;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

endpackage

// ===== rtl/tts_div.sv =====
// ----------------------------------------------------------------------------
// tts_div
// Radix-2 restoring divider for fixed-point quotients, saturated to 32 bits.
// ----------------------------------------------------------------------------
module tts_div #(
  parameter int FRAC_BITS = tts_pkg::FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tts_pkg::DATA_W-1:0] num,
  input  logic [tts_pkg::DATA_W-1:0] den,
  output logic                      done,
  output logic [tts_pkg::DATA_W-1:0] quo
);

  localparam int DW = tts_pkg::DATA_W;
  localparam int QW = 2 * DW;

  logic            busy_r;
  logic            done_r;
  logic            neg_r;
  logic [5:0]      cnt_r;
  logic [QW-1:0]   dvd_r;
  logic [QW-1:0]   q_r;
  logic [DW:0]     rem_r;
  logic [DW-1:0]   d_r;
  logic [DW-1:0]   abs_n;
  logic [DW-1:0]   abs_d;
  logic [DW:0]     rem_sh;
  logic            q_bit;
  logic [QW-1:0]   q_neg;

  assign abs_n  = num[DW-1] ? (~num + 1'b1) : num;
  assign abs_d  = den[DW-1] ? (~den + 1'b1) : den;
  assign rem_sh = {rem_r[DW-1:0], dvd_r[QW-1]};
  assign q_bit  = (rem_sh >= {1'b0, d_r});
  assign q_neg  = ~q_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= num[DW-1] ^ den[DW-1];
        dvd_r  <= QW'(abs_n) << FRAC_BITS;
        d_r    <= abs_d;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= q_bit ? (rem_sh - {1'b0, d_r}) : rem_sh;
        q_r   <= {q_r[QW-2:0], q_bit};
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;

  always_comb begin
    if (!neg_r) begin
      quo = (q_r > QW'(32'h7fff_ffff)) ? 32'h7fff_ffff : q_r[DW-1:0];
    end else begin
      quo = (q_r > QW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : q_neg[DW-1:0];
    end
  end

endmodule

// ===== rtl/tts_core.sv =====
// ----------------------------------------------------------------------------
// tts_core
// Matrix stores and the substitution sequencer with its multiply-accumulate.
// ----------------------------------------------------------------------------
module tts_core #(
  parameter int SIZE      = tts_pkg::SIZE_DEF,
  parameter int FRAC_BITS = tts_pkg::FRAC_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tts_pkg::req_t              req,
  input  tts_pkg::cfg_t              cfg,
  input  logic                       res_take,
  output logic [tts_pkg::DATA_W-1:0] res_value,
  output tts_pkg::stat_t             res_status,
  output tts_pkg::core_stat_t        cstat
);

  localparam int DW     = tts_pkg::DATA_W;
  localparam int AW_ACC = tts_pkg::ACC_W;
  localparam int IDX_W  = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int CNT_W  = IDX_W + 1;
  localparam int DEPTH  = SIZE * SIZE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DW-1:0] ONE_FX = 32'd1 << FRAC_BITS;
  localparam logic [63:0] FMASK = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic signed [AW_ACC-1:0] SAT_MAX = AW_ACC'(64'sh7fff_ffff);
  localparam logic signed [AW_ACC-1:0] SAT_MIN = -AW_ACC'(64'sh8000_0000);

  typedef enum logic [18:0] {
    S_IDLE    = 19'h00001,
    S_RDB     = 19'h00002,
    S_CHECK   = 19'h00004,
    S_DG_RD   = 19'h00008,
    S_DG_CHK  = 19'h00010,
    S_ROW     = 19'h00020,
    S_ENT_RD  = 19'h00040,
    S_ENT_LD  = 19'h00080,
    S_MAC_RD  = 19'h00100,
    S_MAC_MUL = 19'h00200,
    S_MAC_TRN = 19'h00400,
    S_MAC_ACC = 19'h00800,
    S_ENT_WR  = 19'h01000,
    S_DV_RDD  = 19'h02000,
    S_DV_CAP  = 19'h04000,
    S_DV_RD   = 19'h08000,
    S_DV_GO   = 19'h10000,
    S_DV_RUN  = 19'h20000,
    S_NEXT    = 19'h40000
  } state_t;

  state_t state_r;

  logic [DW-1:0] a_mem [DEPTH];
  logic [DW-1:0] b_mem [DEPTH];
  logic [DW-1:0] a_q;
  logic [DW-1:0] b_q;

  logic [ADDR_W-1:0] a_ra, b_ra, a_wa, b_wa;
  logic              a_we, b_we;
  logic [DW-1:0]     b_wd;

  logic [CNT_W-1:0] i_r, j_r, k_r;
  logic [CNT_W-1:0] n_c, n_m1;
  logic [DW-1:0]    d_r;
  logic signed [63:0]       prod_r;
  logic signed [63:0]       trn_r;
  logic signed [AW_ACC-1:0] acc_r;
  logic [DW-1:0]            acc_sat;

  logic          res_valid_r;
  logic [DW-1:0] res_value_r;
  tts_pkg::stat_t res_status_r;

  logic          go;
  logic          in_range;
  logic          bad_cfg;
  logic [ADDR_W-1:0] ext_addr;
  logic [DW-1:0] op_b;
  logic          div_start, div_done;
  logic [DW-1:0] div_quo;
  logic          up;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] r,
                                                 input logic [CNT_W-1:0] c);
    return ADDR_W'(int'(r) * SIZE + int'(c));
  endfunction

  assign up       = cfg.triangle_upper;
  assign go       = req.valid && (state_r == S_IDLE) && !res_valid_r;
  assign in_range = (int'(req.row) < SIZE) && (int'(req.col) < SIZE);
  assign bad_cfg  = (int'(cfg.size_in_use) == 0) || (int'(cfg.size_in_use) > SIZE) ||
                    (cfg.b_unit_diag && !cfg.a_unit_diag);
  assign ext_addr = ADDR_W'(int'(req.row) * SIZE + int'(req.col));
  assign n_c      = CNT_W'(cfg.size_in_use);
  assign n_m1     = n_c - CNT_W'(1);
  assign op_b     = ((k_r == j_r) && cfg.b_unit_diag) ? ONE_FX : b_q;
  assign acc_sat  = (acc_r > SAT_MAX) ? 32'h7fff_ffff :
                    (acc_r < SAT_MIN) ? 32'h8000_0000 : acc_r[DW-1:0];
  assign div_start = (state_r == S_DV_GO);

  always_comb begin
    a_ra = '0;
    b_ra = '0;
    unique case (state_r)
      S_IDLE:   b_ra = ext_addr;
      S_DG_RD:  a_ra = addr_of(k_r, k_r);
      S_ENT_RD: b_ra = addr_of(i_r, j_r);
      S_MAC_RD: begin
        a_ra = addr_of(i_r, k_r);
        b_ra = addr_of(k_r, j_r);
      end
      S_DV_RDD: a_ra = addr_of(i_r, i_r);
      S_DV_RD:  b_ra = addr_of(i_r, j_r);
      default: begin
        a_ra = '0;
        b_ra = '0;
      end
    endcase
  end

  always_comb begin
    a_we = go && (req.cmd == tts_pkg::CMD_WR_A) && in_range;
    a_wa = ext_addr;
    b_we = 1'b0;
    b_wa = addr_of(i_r, j_r);
    b_wd = acc_sat;
    if (go && (req.cmd == tts_pkg::CMD_WR_B) && in_range) begin
      b_we = 1'b1;
      b_wa = ext_addr;
      b_wd = req.value;
    end else if (state_r == S_ENT_WR) begin
      b_we = 1'b1;
    end else if ((state_r == S_DV_RUN) && div_done) begin
      b_we = 1'b1;
      b_wd = div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_wa] <= req.value;
    end
    a_q <= a_mem[a_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_wa] <= b_wd;
    end
    b_q <= b_mem[b_ra];
  end

  tts_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (b_q),
    .den  (d_r),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      if (res_take) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (go) begin
            res_value_r  <= '0;
            res_status_r <= tts_pkg::ST_OK;
            if (req.cmd == tts_pkg::CMD_SOLVE) begin
              state_r <= S_CHECK;
            end else if (!in_range) begin
              res_status_r <= tts_pkg::ST_INVALID;
              res_valid_r  <= 1'b1;
            end else if (req.cmd == tts_pkg::CMD_RD_B) begin
              if ((req.row == req.col) && cfg.b_unit_diag) begin
                res_value_r <= ONE_FX;
                res_valid_r <= 1'b1;
              end else begin
                state_r <= S_RDB;
              end
            end else begin
              res_valid_r <= 1'b1;
            end
          end
        end
        S_RDB: begin
          res_value_r <= b_q;
          res_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_CHECK: begin
          k_r <= '0;
          i_r <= up ? n_m1 : '0;
          if (bad_cfg) begin
            res_status_r <= tts_pkg::ST_INVALID;
            res_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end else if (!cfg.a_unit_diag) begin
            state_r <= S_DG_RD;
          end else begin
            state_r <= S_ROW;
          end
        end
        S_DG_RD: state_r <= S_DG_CHK;
        S_DG_CHK: begin
          if (a_q == '0) begin
            res_status_r <= tts_pkg::ST_SINGULAR;
            res_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end else if (k_r == n_m1) begin
            state_r <= S_ROW;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_DG_RD;
          end
        end
        S_ROW: begin
          j_r <= up ? (i_r + 1'b1) : '0;
          if (up ? ((i_r + 1'b1) < n_c) : (i_r != '0)) begin
            state_r <= S_ENT_RD;
          end else begin
            state_r <= cfg.a_unit_diag ? S_NEXT : S_DV_RDD;
          end
        end
        S_ENT_RD: state_r <= S_ENT_LD;
        S_ENT_LD: begin
          acc_r   <= AW_ACC'(signed'(b_q));
          k_r     <= up ? (i_r + 1'b1) : j_r;
          state_r <= S_MAC_RD;
        end
        S_MAC_RD: state_r <= S_MAC_MUL;
        S_MAC_MUL: begin
          prod_r  <= signed'(a_q) * signed'(op_b);
          state_r <= S_MAC_TRN;
        end
        S_MAC_TRN: begin
          trn_r   <= (prod_r >>> FRAC_BITS) +
                     64'((prod_r[63] && ((prod_r & FMASK) != '0)) ? 1 : 0);
          state_r <= S_MAC_ACC;
        end
        S_MAC_ACC: begin
          acc_r <= acc_r - AW_ACC'(trn_r);
          if (up ? (k_r == j_r) : ((k_r + 1'b1) == i_r)) begin
            state_r <= S_ENT_WR;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_MAC_RD;
          end
        end
        S_ENT_WR: begin
          if (up ? (j_r == n_m1) : ((j_r + 1'b1) == i_r)) begin
            state_r <= cfg.a_unit_diag ? S_NEXT : S_DV_RDD;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_ENT_RD;
          end
        end
        S_DV_RDD: state_r <= S_DV_CAP;
        S_DV_CAP: begin
          d_r     <= a_q;
          j_r     <= up ? i_r : '0;
          state_r <= S_DV_RD;
        end
        S_DV_RD: state_r <= S_DV_GO;
        S_DV_GO: state_r <= S_DV_RUN;
        S_DV_RUN: begin
          if (div_done) begin
            if (up ? (j_r == n_m1) : (j_r == i_r)) begin
              state_r <= S_NEXT;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_DV_RD;
            end
          end
        end
        S_NEXT: begin
          if (up ? (i_r == '0) : (i_r == n_m1)) begin
            res_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            i_r     <= up ? (i_r - 1'b1) : (i_r + 1'b1);
            state_r <= S_ROW;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign res_value       = res_value_r;
  assign res_status      = res_status_r;
  assign cstat.idle      = (state_r == S_IDLE);
  assign cstat.res_valid = res_valid_r;

endmodule

// ===== rtl/triangular_triangular_solve_top.sv =====
// ----------------------------------------------------------------------------
// triangular_triangular_solve_top
// In-place triangular solve B := inv(A) * B on Q16.16 matrices.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A write result is registered in the
// core and then in the output register; a read result may first wait for the
// registered read of the B store. A solve checks the diagonal of A when it is
// stored, updates each entry with the shared multiply-accumulate (about n^3/6
// products for size n), and, when A has a stored diagonal, divides each entry
// in the bit-serial divider (n(n+1)/2 entries). A finished result waits in the
// output register while the next transaction is taken.
module triangular_triangular_solve_top #(
  parameter int SIZE      = tts_pkg::SIZE_DEF,
  parameter int FRAC_BITS = tts_pkg::FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // row [2:0], col [5:3], value [37:6], zero fill [39:38]
  input  logic [tts_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd [1:0]
  input  logic [tts_pkg::CMD_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // read_value [31:0]
  output logic [tts_pkg::DATA_W-1:0]     out_tdata,
  // status [1:0]
  output logic [tts_pkg::STAT_W-1:0]     out_tuser,
  input  logic                           cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  tts_pkg::cfg_t       cfg_r;
  tts_pkg::req_t       req;
  tts_pkg::core_stat_t cstat;
  logic [tts_pkg::DATA_W-1:0] res_value;
  tts_pkg::stat_t      res_status;
  logic                res_take;
  logic                out_valid_r;
  logic [tts_pkg::DATA_W-1:0] out_data_r;
  logic [tts_pkg::STAT_W-1:0] out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.triangle_upper <= 1'b1;
      cfg_r.a_unit_diag    <= 1'b0;
      cfg_r.b_unit_diag    <= 1'b0;
      cfg_r.size_in_use    <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tts_pkg::REG_TRI_UPPER: cfg_r.triangle_upper <= cfg_wdata[0];
        tts_pkg::REG_A_UNIT:    cfg_r.a_unit_diag    <= cfg_wdata[0];
        tts_pkg::REG_B_UNIT:    cfg_r.b_unit_diag    <= cfg_wdata[0];
        tts_pkg::REG_SIZE:      cfg_r.size_in_use    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = cstat.idle && !cstat.res_valid;
  assign req.valid = in_tvalid && in_tready;
  assign req.cmd   = tts_pkg::cmd_t'(in_tuser);
  assign req.row   = in_tdata[2:0];
  assign req.col   = in_tdata[5:3];
  assign req.value = in_tdata[37:6];

  tts_core #(
    .SIZE     (SIZE),
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .cfg       (cfg_r),
    .res_take  (res_take),
    .res_value (res_value),
    .res_status(res_status),
    .cstat     (cstat)
  );

  assign res_take = cstat.res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res_value;
      out_user_r  <= res_status;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after a transaction");

  a_solve_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == tts_pkg::CMD_SOLVE)) |=> !cstat.res_valid)
    else $error("solve answered without running");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= tts_pkg::ST_INVALID))
    else $error("undefined status code");

  a_take_moves_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (out_tvalid && !cstat.res_valid))
    else $error("result lost between core and output register");
`endif

endmodule

// ===== bench/triangular_triangular_solve_top_tb.sv =====
// ----------------------------------------------------------------------------
// triangular_triangular_solve_top_tb
// Self-checking bench for the in-place Q16.16 triangular solve.
// A short directed table covers field extremes, a singular A, bad
// configurations and the unit diagonal of B. Then a fill pass writes every
// entry of both stores, and random phases mix writes, reads and solves under
// several register settings. Each result transaction is checked against the
// table's own values or a bench predictor. The sender works in bursts and the
// receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module triangular_triangular_solve_top_tb;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [tts_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [tts_pkg::CMD_W-1:0]      in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [tts_pkg::DATA_W-1:0]     out_tdata;
  logic [tts_pkg::STAT_W-1:0]     out_tuser;
  logic                           cfg_we;
  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [tts_pkg::CFG_DATA_W-1:0] cfg_wdata;

  triangular_triangular_solve_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  typedef struct {
    logic [tts_pkg::DATA_W-1:0] read_value;
    tts_pkg::stat_t             status;
  } answer_t;

  typedef struct {
    bit                         set_cfg;
    logic [3:0]                 cfg_vals [4];
    tts_pkg::cmd_t              cmd;
    logic [tts_pkg::POS_W-1:0]  row;
    logic [tts_pkg::POS_W-1:0]  col;
    logic [tts_pkg::DATA_W-1:0] value;
    bit                         typed;
    logic [tts_pkg::DATA_W-1:0] exp_value;
    tts_pkg::stat_t             exp_status;
  } step_t;

  answer_t pending_answers[$];
  int      error_count = 0;
  bit      hold_request = 0;
  int      burst_left = 0;

  logic [tts_pkg::DATA_W-1:0] mat_a [64];
  logic [tts_pkg::DATA_W-1:0] mat_b [64];
  logic              m_upper;
  logic              m_a_unit;
  logic              m_b_unit;
  logic [3:0]        m_size;

  function automatic logic [31:0] sat32(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic longint fx_product(logic [31:0] a, logic [31:0] b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    return p / 65536;
  endfunction

  function automatic logic [31:0] fx_quotient(logic [31:0] b, logic [31:0] d);
    longint num;
    num = longint'($signed(b)) * 65536;
    return sat32(num / longint'($signed(d)));
  endfunction

  function automatic logic [31:0] b_value(int r, int c);
    if (r == c && m_b_unit) return 32'h00010000;
    return mat_b[r*8+c];
  endfunction

  function automatic bit outside_tri(int i, int j);
    return m_upper ? (j < i) : (j > i);
  endfunction

  task automatic substitute_row(int n, int i);
    longint acc;
    int lo, hi;
    for (int j = 0; j < n; j++) begin
      if (j != i && !outside_tri(i, j)) begin
        lo = m_upper ? i + 1 : j;
        hi = m_upper ? j : i - 1;
        acc = longint'($signed(mat_b[i*8+j]));
        for (int k = lo; k <= hi; k++)
          acc -= fx_product(mat_a[i*8+k], b_value(k, j));
        mat_b[i*8+j] = sat32(acc);
      end
    end
    if (!m_a_unit)
      for (int j = 0; j < n; j++)
        if (!outside_tri(i, j))
          mat_b[i*8+j] = fx_quotient(mat_b[i*8+j], mat_a[i*8+i]);
  endtask

  task automatic solve_predict(output tts_pkg::stat_t st);
    int n;
    n = m_size;
    st = tts_pkg::ST_OK;
    if (n == 0 || n > 8 || (m_b_unit && !m_a_unit)) begin
      st = tts_pkg::ST_INVALID;
      return;
    end
    if (!m_a_unit)
      for (int i = 0; i < n; i++)
        if (mat_a[i*8+i] == 0) begin
          st = tts_pkg::ST_SINGULAR;
          return;
        end
    if (m_upper)
      for (int i = n - 1; i >= 0; i--) substitute_row(n, i);
    else
      for (int i = 0; i < n; i++) substitute_row(n, i);
  endtask

  task automatic trsm_predict(tts_pkg::cmd_t cmd, int r, int c, logic [31:0] v,
                              output answer_t ans);
    tts_pkg::stat_t st;
    ans.read_value = '0;
    ans.status = tts_pkg::ST_OK;
    case (cmd)
      tts_pkg::CMD_WR_A: mat_a[r*8+c] = v;
      tts_pkg::CMD_WR_B: mat_b[r*8+c] = v;
      tts_pkg::CMD_RD_B: ans.read_value = b_value(r, c);
      default: begin
        solve_predict(st);
        ans.status = st;
      end
    endcase
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result transaction: read_value %h status %0d", out_tdata, out_tuser);
        error_count++;
      end else begin
        e = pending_answers.pop_front();
        if (out_tdata !== e.read_value) begin
          $error("read_value expected %h actual %h", e.read_value, out_tdata);
          error_count++;
        end
        if (out_tuser !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    int seg, mode;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        out_tready <= 0;
        repeat (400) @(posedge clk);
      end
      seg = $urandom_range(5, 40);
      mode = $urandom_range(0, 2);
      repeat (seg) begin
        case (mode)
          0: out_tready <= 1;
          1: out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_item(tts_pkg::cmd_t cmd, int r, int c, logic [31:0] v,
                           bit typed, logic [31:0] tv, tts_pkg::stat_t ts);
    answer_t ans;
    int gap;
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, v, c[2:0], r[2:0]};
    do @(posedge clk); while (!in_tready);
    trsm_predict(cmd, r, c, v, ans);
    if (typed) begin
      ans.read_value = tv;
      ans.status = ts;
    end
    pending_answers.push_back(ans);
    if (--burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain;
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [3:0] upper, logic [3:0] a_unit, logic [3:0] b_unit,
                            logic [3:0] size);
    logic [3:0] vals [4];
    vals = '{upper, a_unit, b_unit, size};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1;
      cfg_addr  <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    m_upper  = upper[0];
    m_a_unit = a_unit[0];
    m_b_unit = b_unit[0];
    m_size   = size;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(bit diag_a);
    int sel;
    sel = $urandom_range(0, 99);
    if (diag_a && sel < 5) return 32'h0;
    if (sel < 50) return $urandom_range(0, 32'h80000) - 32'h40000;
    if (sel < 60) begin
      case ($urandom_range(0, 4))
        0: return 32'h7fffffff;
        1: return 32'h80000000;
        2: return 32'h00010000;
        3: return 32'hffffffff;
        default: return diag_a ? 32'h00000001 : 32'h0;
      endcase
    end
    if (sel < 80) return $urandom_range(0, 32'h1000000) - 32'h800000;
    return $urandom();
  endfunction

  step_t steps [$];

  function automatic step_t mk(tts_pkg::cmd_t cmd, int r, int c, logic [31:0] v,
                               bit typed, logic [31:0] tv, tts_pkg::stat_t ts);
    step_t s;
    s.set_cfg = 0;
    s.cfg_vals = '{4'd1, 4'd0, 4'd0, 4'd8};
    s.cmd = cmd; s.row = 3'(r); s.col = 3'(c); s.value = v;
    s.typed = typed; s.exp_value = tv; s.exp_status = ts;
    return s;
  endfunction

  initial begin
    step_t s;
    int r, c, sel;
    tts_pkg::cmd_t cmd;
    logic [3:0] phase_cfg [10][4];

    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    cfg_we = 0; cfg_addr = '0; cfg_wdata = '0;
    for (int i = 0; i < 64; i++) begin
      mat_a[i] = '0;
      mat_b[i] = '0;
    end
    m_upper = 1; m_a_unit = 0; m_b_unit = 0; m_size = 4'd8;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    steps.push_back(mk(tts_pkg::CMD_WR_A, 0, 0, 32'h7fffffff, 1, 32'h0, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_WR_B, 0, 0, 32'h80000000, 1, 32'h0, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_RD_B, 0, 0, 32'h0, 1, 32'h80000000, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_WR_B, 7, 7, 32'hffffffff, 1, 32'h0, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_RD_B, 7, 7, 32'h0, 1, 32'hffffffff, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_WR_A, 7, 0, 32'h12345678, 1, 32'h0, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_WR_B, 3, 5, 32'h0, 1, 32'h0, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_RD_B, 3, 5, 32'h0, 1, 32'h0, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_WR_B, 5, 3, 32'h00010000, 1, 32'h0, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_RD_B, 5, 3, 32'h0, 1, 32'h00010000, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_WR_A, 0, 0, 32'h0, 1, 32'h0, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_SOLVE, 0, 0, 32'h0, 1, 32'h0, tts_pkg::ST_SINGULAR));
    steps.push_back(mk(tts_pkg::CMD_RD_B, 0, 0, 32'h0, 1, 32'h80000000, tts_pkg::ST_OK));
    s = mk(tts_pkg::CMD_SOLVE, 0, 0, 32'h0, 1, 32'h0, tts_pkg::ST_INVALID);
    s.set_cfg = 1; s.cfg_vals = '{4'd1, 4'd0, 4'd1, 4'd8};
    steps.push_back(s);
    steps.push_back(mk(tts_pkg::CMD_RD_B, 0, 0, 32'h0, 1, 32'h00010000, tts_pkg::ST_OK));
    steps.push_back(mk(tts_pkg::CMD_RD_B, 3, 5, 32'h0, 1, 32'h0, tts_pkg::ST_OK));
    s = mk(tts_pkg::CMD_SOLVE, 0, 0, 32'h0, 1, 32'h0, tts_pkg::ST_INVALID);
    s.set_cfg = 1; s.cfg_vals = '{4'd0, 4'd1, 4'd0, 4'd0};
    steps.push_back(s);
    s = mk(tts_pkg::CMD_SOLVE, 0, 0, 32'h0, 1, 32'h0, tts_pkg::ST_INVALID);
    s.set_cfg = 1; s.cfg_vals = '{4'd1, 4'd1, 4'd1, 4'd15};
    steps.push_back(s);
    s = mk(tts_pkg::CMD_SOLVE, 0, 0, 32'h0, 1, 32'h0, tts_pkg::ST_INVALID);
    s.set_cfg = 1; s.cfg_vals = '{4'd0, 4'd0, 4'd0, 4'd9};
    steps.push_back(s);

    foreach (steps[i]) begin
      if (steps[i].set_cfg) begin
        drain();
        write_regs(steps[i].cfg_vals[0], steps[i].cfg_vals[1],
                   steps[i].cfg_vals[2], steps[i].cfg_vals[3]);
      end
      send_item(steps[i].cmd, steps[i].row, steps[i].col, steps[i].value,
                steps[i].typed, steps[i].exp_value, steps[i].exp_status);
    end

    drain();
    write_regs(4'd1, 4'd0, 4'd0, 4'd8);
    for (int i = 0; i < 64; i++) begin
      send_item(tts_pkg::CMD_WR_A, i / 8, i % 8,
                pick_value(0) | ((i / 8 == i % 8) ? 32'h100 : 0), 0, 0, tts_pkg::ST_OK);
      send_item(tts_pkg::CMD_WR_B, i / 8, i % 8, pick_value(0), 0, 0, tts_pkg::ST_OK);
    end

    phase_cfg = '{'{4'd1, 4'd0, 4'd0, 4'd8}, '{4'd0, 4'd0, 4'd0, 4'd8},
                  '{4'd1, 4'd1, 4'd1, 4'd1}, '{4'd0, 4'd1, 4'd0, 4'd8},
                  '{4'd1, 4'd1, 4'd0, 4'd3}, '{4'd0, 4'd1, 4'd1, 4'd5},
                  '{4'd1, 4'd0, 4'd0, 4'd2}, '{4'd0, 4'd0, 4'd1, 4'd4},
                  '{4'd0, 4'd0, 4'd0, 4'd1}, '{4'd1, 4'd1, 4'd1, 4'd8}};
    for (int p = 0; p < 10; p++) begin
      drain();
      write_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      if (p == 2) hold_request = 1;
      repeat (55) begin
        sel = $urandom_range(0, 99);
        r = $urandom_range(0, 7);
        c = $urandom_range(0, 7);
        if (sel < 35) cmd = tts_pkg::CMD_WR_A;
        else if (sel < 65) cmd = tts_pkg::CMD_WR_B;
        else if (sel < 91) cmd = tts_pkg::CMD_RD_B;
        else cmd = tts_pkg::CMD_SOLVE;
        send_item(cmd, r, c, pick_value(cmd == tts_pkg::CMD_WR_A && r == c), 0, 0,
                  tts_pkg::ST_OK);
      end
      send_item(tts_pkg::CMD_SOLVE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom(),
                0, 0, tts_pkg::ST_OK);
    end

    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_answers.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
